@@ rtl/rrmo_pkg.sv @@
// ----------------------------------------------------------------------------
// rrmo_pkg
// shared constants, types and the arctangent table of the range residual block
// ----------------------------------------------------------------------------
`default_nettype none

package rrmo_pkg;

	localparam int CORDIC_STAGES_DEF = 18;
	localparam int FRAC_BITS_DEF     = 16;

	localparam longint PI_30      = 64'sd3373259426;
	localparam longint TWO_PI_30  = 64'sd6746518852;
	localparam longint HALF_PI_30 = 64'sd1686629713;
	localparam longint GAIN_Q30   = 64'sd652032874;

	// rotator vector width (8 guard bits) and angle accumulator width
	localparam int XW = 42;
	localparam int ZW = 34;

	// configuration register indexes
	localparam logic [1:0] REG_OFFSET_X = 2'd0;
	localparam logic [1:0] REG_OFFSET_Y = 2'd1;

	typedef struct packed {
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] lx;
		logic signed [31:0] ly;
		logic        [30:0] meas;
	} side_t;

	typedef struct packed {
		logic [30:0] meas;
		logic        huge;
	} sq_side_t;

	// truncated atan(2^-i) in Q30
	function automatic logic signed [ZW-1:0] atan_q30(input int i);
		logic signed [ZW-1:0] v;
		case (i)
			0:  v = 34'sh03243F6A8;
			1:  v = 34'sh01DAC6705;
			2:  v = 34'sh00FADBAFC;
			3:  v = 34'sh007F56EA6;
			4:  v = 34'sh003FEAB76;
			5:  v = 34'sh001FFD55B;
			6:  v = 34'sh000FFFAAA;
			7:  v = 34'sh0007FFF55;
			8:  v = 34'sh0003FFFEA;
			9:  v = 34'sh0001FFFFD;
			10: v = 34'sh0000FFFFF;
			11: v = 34'sh00007FFFF;
			12: v = 34'sh00003FFFF;
			13: v = 34'sh00001FFFF;
			14: v = 34'sh00000FFFF;
			15: v = 34'sh000007FFF;
			16: v = 34'sh000003FFF;
			17: v = 34'sh000001FFF;
			18: v = 34'sh000000FFF;
			19: v = 34'sh0000007FF;
			20: v = 34'sh0000003FF;
			21: v = 34'sh0000001FF;
			22: v = 34'sh0000000FF;
			23: v = 34'sh00000007F;
			24: v = 34'sh00000003F;
			25: v = 34'sh00000001F;
			26: v = 34'sh00000000F;
			27: v = 34'sh000000007;
			28: v = 34'sh000000003;
			29: v = 34'sh000000001;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

@@ rtl/rrmo_if.sv @@
// ----------------------------------------------------------------------------
// rrmo_if
// valid/ready channels for pose items and residual results
// ----------------------------------------------------------------------------
`default_nettype none

interface rrmo_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] robot_x;
	logic signed [31:0] robot_y;
	logic signed [23:0] robot_heading;
	logic signed [23:0] turret_angle;
	logic signed [31:0] landmark_x;
	logic signed [31:0] landmark_y;
	logic        [30:0] measured_distance;

	modport source (output valid, robot_x, robot_y, robot_heading, turret_angle,
		landmark_x, landmark_y, measured_distance, input ready);
	modport sink (input valid, robot_x, robot_y, robot_heading, turret_angle,
		landmark_x, landmark_y, measured_distance, output ready);
endinterface

interface rrmo_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] residual;
	logic               floor_applied;
	logic               residual_clipped;

	modport source (output valid, residual, floor_applied, residual_clipped,
		input ready);
	modport sink (input valid, residual, floor_applied, residual_clipped,
		output ready);
endinterface

`default_nettype wire

@@ rtl/range_residual_with_mount_offset.sv @@
// ----------------------------------------------------------------------------
// range_residual_with_mount_offset
// range residual from robot pose, turret yaw and rotated sensor mount offset
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction is accepted every cycle unless the output
// stalls; each result passes 4 angle-reduction and scaling stages, one stage
// per cordic iteration, 3 offset/square stages, 32 square-root stages and the
// output register. The whole pipeline holds when a finished result is not
// taken, so the input is ready whenever the output register is empty or being
// read. Mount offsets are to be written through the cfg port while the
// pipeline is empty, which the block does not enforce; they reset to zero.
`default_nettype none

module range_residual_with_mount_offset
	import rrmo_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
	parameter int FRAC_BITS     = FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	rrmo_in_if.sink          in_ch,
	rrmo_out_if.source       out_ch
);

	localparam int     ANG_SHIFT = 30 - FRAC_BITS;
	localparam longint ROUND_A   = longint'(1) << (ANG_SHIFT - 1);
	localparam longint PI_Q      = (PI_30 + ROUND_A) >>> ANG_SHIFT;
	localparam longint TWO_PI_Q  = (TWO_PI_30 + ROUND_A) >>> ANG_SHIFT;
	// bias that keeps the angle numerator positive for floor-mod
	localparam longint WRAP_C    = (longint'(1) << 24) / TWO_PI_Q + 2;
	localparam longint BIAS      = PI_Q + TWO_PI_Q * WRAP_C;
	localparam int     RS        = 40;
	localparam longint RECIP     = ((longint'(1) << RS) + TWO_PI_Q - 1) / TWO_PI_Q;

	logic signed [31:0] offset_x_q;
	logic signed [31:0] offset_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q <= '0;
			offset_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OFFSET_X: offset_x_q <= cfg_data;
				REG_OFFSET_Y: offset_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic out_v_q;

	assign en          = !out_v_q || out_ch.ready;
	assign in_ch.ready = en;

	// stage 1: angle sum, gain scaling products
	logic               v_s1;
	logic signed [24:0] a_s1;
	logic signed [63:0] px_s1;
	logic signed [63:0] py_s1;
	side_t              d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1      <= 25'(in_ch.robot_heading) + 25'(in_ch.turret_angle);
			px_s1     <= 64'(offset_x_q) * GAIN_Q30;
			py_s1     <= 64'(offset_y_q) * GAIN_Q30;
			d_s1.rx   <= in_ch.robot_x;
			d_s1.ry   <= in_ch.robot_y;
			d_s1.lx   <= in_ch.landmark_x;
			d_s1.ly   <= in_ch.landmark_y;
			d_s1.meas <= in_ch.measured_distance;
		end
	end

	// stage 2: quotient estimate by reciprocal
	logic signed [31:0] vps_w;
	logic        [29:0] vp_w;

	assign vps_w = 32'(a_s1) + 32'(BIAS);
	assign vp_w  = vps_w[29:0];

	logic                 v_s2;
	logic        [29:0]   vp_s2;
	logic        [59:0]   qm_s2;
	logic signed [XW-1:0] x_s2;
	logic signed [XW-1:0] y_s2;
	side_t                d_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vp_s2 <= vp_w;
			qm_s2 <= 60'(vp_w) * 60'(RECIP);
			x_s2  <= px_s1[XW+21:22];
			y_s2  <= py_s1[XW+21:22];
			d_s2  <= d_s1;
		end
	end

	// stage 3: remainder, estimate may be one high
	logic [19:0] q_w;
	logic [29:0] qt_w;

	assign q_w  = qm_s2[RS+19:RS];
	assign qt_w = 30'(q_w) * 30'(TWO_PI_Q);

	logic                 v_s3;
	logic signed [30:0]   r_s3;
	logic signed [XW-1:0] x_s3;
	logic signed [XW-1:0] y_s3;
	side_t                d_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s3 <= $signed({1'b0, vp_s2}) - $signed({1'b0, qt_w});
			x_s3 <= x_s2;
			y_s3 <= y_s2;
			d_s3 <= d_s2;
		end
	end

	// stage 4: wrapped angle to Q30, fold into the right half plane
	logic signed [30:0]   m_w;
	logic signed [30:0]   zq_w;
	logic signed [ZW-1:0] z_w;

	assign m_w  = (r_s3 < 0) ? r_s3 + 31'(TWO_PI_Q) : r_s3;
	assign zq_w = m_w - 31'(PI_Q);
	assign z_w  = ZW'(zq_w) <<< ANG_SHIFT;

	logic                 v_s4;
	logic signed [ZW-1:0] z_s4;
	logic signed [XW-1:0] x_s4;
	logic signed [XW-1:0] y_s4;
	side_t                d_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s4 <= d_s3;
			if (z_w > ZW'(HALF_PI_30)) begin
				z_s4 <= z_w - ZW'(PI_30);
				x_s4 <= -x_s3;
				y_s4 <= -y_s3;
			end else if (z_w < -ZW'(HALF_PI_30)) begin
				z_s4 <= z_w + ZW'(PI_30);
				x_s4 <= -x_s3;
				y_s4 <= -y_s3;
			end else begin
				z_s4 <= z_w;
				x_s4 <= x_s3;
				y_s4 <= y_s3;
			end
		end
	end

	logic                 cv_w;
	logic signed [XW-1:0] cx_w;
	logic signed [XW-1:0] cy_w;
	side_t                cd_w;

	rrmo_cordic #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s4),
		.in_x      (x_s4),
		.in_y      (y_s4),
		.in_z      (z_s4),
		.in_side   (d_s4),
		.out_valid (cv_w),
		.out_x     (cx_w),
		.out_y     (cy_w),
		.out_side  (cd_w)
	);

	// stage 5: drop guard bits, landmark minus sensor position
	logic signed [XW-1:0] xg_w;
	logic signed [XW-1:0] yg_w;

	assign xg_w = (cx_w + XW'(128)) >>> 8;
	assign yg_w = (cy_w + XW'(128)) >>> 8;

	logic               v_s5;
	logic signed [35:0] dx_s5;
	logic signed [35:0] dy_s5;
	logic        [30:0] meas_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= cv_w;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s5   <= 36'(cd_w.lx) - 36'(cd_w.rx) - 36'(xg_w);
			dy_s5   <= 36'(cd_w.ly) - 36'(cd_w.ry) - 36'(yg_w);
			meas_s5 <= cd_w.meas;
		end
	end

	// stage 6: magnitudes and squares
	logic [35:0] ax_w;
	logic [35:0] ay_w;

	assign ax_w = (dx_s5 < 0) ? 36'(-dx_s5) : 36'(dx_s5);
	assign ay_w = (dy_s5 < 0) ? 36'(-dy_s5) : 36'(dy_s5);

	logic        v_s6;
	logic [63:0] sx_s6;
	logic [63:0] sy_s6;
	logic        huge_s6;
	logic [30:0] meas_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s6   <= 64'(ax_w[31:0]) * 64'(ax_w[31:0]);
			sy_s6   <= 64'(ay_w[31:0]) * 64'(ay_w[31:0]);
			huge_s6 <= (|ax_w[35:32]) || (|ay_w[35:32]);
			meas_s6 <= meas_s5;
		end
	end

	// stage 7: sum of squares, overflow counts as huge
	logic [64:0] sum_w;

	assign sum_w = 65'(sx_s6) + 65'(sy_s6);

	logic        v_s7;
	logic [63:0] n_s7;
	sq_side_t    d_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s7      <= sum_w[63:0];
			d_s7.huge <= huge_s6 || sum_w[64];
			d_s7.meas <= meas_s6;
		end
	end

	logic        sv_w;
	logic [31:0] root_w;
	logic [34:0] rem_w;
	sq_side_t    sd_w;

	rrmo_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.in_n      (n_s7),
		.in_side   (d_s7),
		.out_valid (sv_w),
		.out_root  (root_w),
		.out_rem   (rem_w),
		.out_side  (sd_w)
	);

	// output stage: round, floor at one lsb, saturate
	logic [32:0]        dist_w;
	logic [32:0]        distf_w;
	logic signed [33:0] diff_w;
	logic               lo_w;

	assign dist_w  = 33'(root_w) + 33'(rem_w > 35'(root_w));
	assign distf_w = (dist_w == '0) ? 33'd1 : dist_w;
	assign diff_w  = $signed(34'(sd_w.meas)) - $signed(34'(distf_w));
	assign lo_w    = diff_w < -34'sd2147483648;

	logic signed [31:0] res_q;
	logic               floor_q;
	logic               clip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= sv_w;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sd_w.huge) begin
				res_q   <= 32'sh80000000;
				floor_q <= 1'b0;
				clip_q  <= 1'b1;
			end else begin
				res_q   <= lo_w ? 32'sh80000000 : diff_w[31:0];
				floor_q <= (dist_w == '0);
				clip_q  <= lo_w;
			end
		end
	end

	assign out_ch.valid            = out_v_q;
	assign out_ch.residual         = res_q;
	assign out_ch.floor_applied    = floor_q;
	assign out_ch.residual_clipped = clip_q;

endmodule

`default_nettype wire

@@ rtl/rrmo_cordic.sv @@
// ----------------------------------------------------------------------------
// rrmo_cordic
// pipelined rotation-mode cordic, one register stage per iteration
// ----------------------------------------------------------------------------
`default_nettype none

module rrmo_cordic
	import rrmo_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic signed [XW-1:0] in_x,
	input  wire logic signed [XW-1:0] in_y,
	input  wire logic signed [ZW-1:0] in_z,
	input  wire side_t                in_side,
	output logic                      out_valid,
	output logic signed [XW-1:0]      out_x,
	output logic signed [XW-1:0]      out_y,
	output side_t                     out_side
);

	localparam int NST = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

	logic                 v_s [0:NST];
	logic signed [XW-1:0] x_s [0:NST];
	logic signed [XW-1:0] y_s [0:NST];
	logic signed [ZW-1:0] z_s [0:NST];
	side_t                d_s [0:NST];

	assign v_s[0] = in_valid;
	assign x_s[0] = in_x;
	assign y_s[0] = in_y;
	assign z_s[0] = in_z;
	assign d_s[0] = in_side;

	for (genvar i = 0; i < NST; i++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[i+1] <= d_s[i];
				if (z_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_q30(i);
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_q30(i);
				end
			end
		end
	end

	assign out_valid = v_s[NST];
	assign out_x     = x_s[NST];
	assign out_y     = y_s[NST];
	assign out_side  = d_s[NST];

endmodule

`default_nettype wire

@@ rtl/rrmo_isqrt.sv @@
// ----------------------------------------------------------------------------
// rrmo_isqrt
// pipelined 64-bit integer square root, one result bit per register stage
// ----------------------------------------------------------------------------
`default_nettype none

module rrmo_isqrt
	import rrmo_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        in_valid,
	input  wire logic [63:0] in_n,
	input  wire sq_side_t    in_side,
	output logic             out_valid,
	output logic [31:0]      out_root,
	output logic [34:0]      out_rem,
	output sq_side_t         out_side
);

	localparam int NB = 32;

	logic        v_s [0:NB];
	logic [63:0] n_s [0:NB];
	logic [31:0] r_s [0:NB];
	logic [34:0] m_s [0:NB];
	sq_side_t    d_s [0:NB];

	assign v_s[0] = in_valid;
	assign n_s[0] = in_n;
	assign r_s[0] = '0;
	assign m_s[0] = '0;
	assign d_s[0] = in_side;

	for (genvar k = 0; k < NB; k++) begin : g_bit
		logic [34:0] rem_w;
		logic [34:0] trial_w;

		// bring down the next two radicand bits, try root*4+1
		assign rem_w   = {m_s[k][32:0], n_s[k][63:62]};
		assign trial_w = {1'b0, r_s[k], 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[k+1] <= d_s[k];
				n_s[k+1] <= {n_s[k][61:0], 2'b00};
				if (rem_w >= trial_w) begin
					m_s[k+1] <= rem_w - trial_w;
					r_s[k+1] <= {r_s[k][30:0], 1'b1};
				end else begin
					m_s[k+1] <= rem_w;
					r_s[k+1] <= {r_s[k][30:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = v_s[NB];
	assign out_root  = r_s[NB];
	assign out_rem   = m_s[NB];
	assign out_side  = d_s[NB];

endmodule

`default_nettype wire

@@ tb/sv/rrmo_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// rrmo_tb_pkg
// range residual prediction and the queue of expected residuals
// ----------------------------------------------------------------------------
`default_nettype none

package rrmo_tb_pkg;
	import rrmo_pkg::*;

	typedef struct {
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [23:0] heading;
		logic signed [23:0] turret;
		logic signed [31:0] lx;
		logic signed [31:0] ly;
		logic        [30:0] meas;
	} pose_item_t;

	typedef struct {
		logic signed [31:0] residual;
		logic               floored;
		logic               clipped;
	} residual_t;

	localparam int     ASHIFT  = 30 - FRAC_BITS_DEF;
	localparam longint PI_Q    = (PI_30 + (64'sd1 <<< (ASHIFT - 1))) >>> ASHIFT;
	localparam longint TWOPI_Q = (TWO_PI_30 + (64'sd1 <<< (ASHIFT - 1))) >>> ASHIFT;

	function automatic logic [63:0] round_sqrt(input logic [63:0] n);
		logic [63:0] res, bitv, rem;
		res = 0;
		bitv = 64'd1 << 62;
		rem = n;
		while (bitv > rem)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		if (rem > res)
			res = res + 1;
		return res;
	endfunction

	function automatic residual_t predict_residual(input pose_item_t it,
			input logic signed [31:0] offx, input logic signed [31:0] offy);
		longint a, m, z, x, y, xs, ys, dx, dy, d;
		logic [63:0] ax, ay, sq, sum, dist_v;
		logic huge;
		residual_t r;
		a = longint'(it.heading) + longint'(it.turret);
		m = (a + PI_Q) % TWOPI_Q;
		if (m < 0)
			m += TWOPI_Q;
		z = (m - PI_Q) * (64'sd1 <<< ASHIFT);
		x = (longint'(offx) * GAIN_Q30) >>> 22;
		y = (longint'(offy) * GAIN_Q30) >>> 22;
		if (z > HALF_PI_30) begin
			z -= PI_30; x = -x; y = -y;
		end else if (z < -HALF_PI_30) begin
			z += PI_30; x = -x; y = -y;
		end
		for (int i = 0; i < CORDIC_STAGES_DEF && i < 32; i++) begin
			xs = y >>> i;
			ys = x >>> i;
			if (z >= 0) begin
				x -= xs; y += ys; z -= longint'(atan_q30(i));
			end else begin
				x += xs; y -= ys; z += longint'(atan_q30(i));
			end
		end
		x = (x + 128) >>> 8;
		y = (y + 128) >>> 8;
		dx = longint'(it.lx) - (longint'(it.rx) + x);
		dy = longint'(it.ly) - (longint'(it.ry) + y);
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		huge = 0;
		dist_v = 0;
		if (ax >= 64'h1_0000_0000 || ay >= 64'h1_0000_0000) begin
			huge = 1;
		end else begin
			sq = ax * ax;
			sum = sq + ay * ay;
			if (sum < sq)
				huge = 1;
			else
				dist_v = round_sqrt(sum);
		end
		r.floored = 0;
		r.clipped = 0;
		if (huge) begin
			r.residual = 32'sh8000_0000;
			r.clipped = 1;
		end else begin
			if (dist_v == 0) begin
				dist_v = 1;
				r.floored = 1;
			end
			d = longint'({1'b0, it.meas}) - longint'(dist_v);
			if (d < -64'sd2147483648) begin
				d = -64'sd2147483648;
				r.clipped = 1;
			end
			r.residual = d[31:0];
		end
		return r;
	endfunction

	class residual_scoreboard;
		residual_t pending[$];
		logic signed [31:0] offx, offy;
		int errors, checked, floors, clips;

		function void note_pose(pose_item_t it);
			pending.push_back(predict_residual(it, offx, offy));
		endfunction

		function void check_result(residual_t got);
			residual_t e;
			if (pending.size() == 0) begin
				$error("residual with no pose pending: %0d", got.residual);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			floors += got.floored;
			clips += got.clipped;
			if (got.residual !== e.residual) begin
				$error("residual: expected %0d actual %0d", e.residual, got.residual);
				errors++;
			end
			if (got.floored !== e.floored) begin
				$error("floor_applied: expected %0b actual %0b", e.floored, got.floored);
				errors++;
			end
			if (got.clipped !== e.clipped) begin
				$error("residual_clipped: expected %0b actual %0b", e.clipped,
					got.clipped);
				errors++;
			end
		endfunction
	endclass

endpackage

`default_nettype wire

@@ tb/sv/tb_range_residual_with_mount_offset.sv @@
// ----------------------------------------------------------------------------
// tb_range_residual_with_mount_offset
// drives random and corner poses through the range residual pipeline under
// random idling and back-pressure, checking every result against a predictor
// ----------------------------------------------------------------------------
`default_nettype none

module tb_range_residual_with_mount_offset;
	timeunit 1ns;
	timeprecision 1ps;
	import rrmo_pkg::*;
	import rrmo_tb_pkg::*;

	localparam int LATENCY = CORDIC_STAGES_DEF + 40;
	localparam int STALL_LIMIT = 5000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	rrmo_in_if  in_ch();
	rrmo_out_if out_ch();

	range_residual_with_mount_offset DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	residual_scoreboard sb = new();
	bit quiet;       // no idling on either side
	bit hold_sink;   // long receiver hold-off
	bit done;
	int idle_cycles;

	always #10 clk = ~clk;

	initial begin
		in_ch.valid = 0;
		in_ch.robot_x = '0;
		in_ch.robot_y = '0;
		in_ch.robot_heading = '0;
		in_ch.turret_angle = '0;
		in_ch.landmark_x = '0;
		in_ch.landmark_y = '0;
		in_ch.measured_distance = '0;
		out_ch.ready = 0;
	end

	// result side: sample at rising edge, change ready at falling edge
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result('{out_ch.residual, out_ch.floor_applied,
				out_ch.residual_clipped});
		if (arst_n && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	always @(negedge clk) begin
		if (!arst_n || hold_sink)
			out_ch.ready <= 0;
		else
			out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 21);
	end

	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT && !done) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_OFFSET_X)
			sb.offx = val;
		else if (idx == REG_OFFSET_Y)
			sb.offy = val;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// one pose transaction, with random leading idle cycles
	task automatic send_pose(input pose_item_t it);
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 21) begin
			in_ch.valid <= 0;
			@(negedge clk);
		end
		in_ch.valid <= 1;
		in_ch.robot_x <= it.rx;
		in_ch.robot_y <= it.ry;
		in_ch.robot_heading <= it.heading;
		in_ch.turret_angle <= it.turret;
		in_ch.landmark_x <= it.lx;
		in_ch.landmark_y <= it.ly;
		in_ch.measured_distance <= it.meas;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_pose(it);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		in_ch.valid <= 0;
	endtask

	function automatic logic [31:0] rand_coord(input int sel);
		case (sel)
			0: return $urandom;
			1: return 32'($signed($urandom_range(2000000)) - 1000000);
			2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(20000)) - 10000);
		endcase
	endfunction

	function automatic pose_item_t rand_pose();
		pose_item_t it;
		int mode;
		mode = $urandom_range(9);
		it.rx = rand_coord($urandom_range(3));
		it.ry = rand_coord($urandom_range(3));
		it.heading = $urandom_range(3) == 0 ? 24'($urandom) :
			24'($signed($urandom_range(500000)) - 250000);
		it.turret = $urandom_range(3) == 0 ? 24'($urandom) :
			24'($signed($urandom_range(500000)) - 250000);
		it.lx = rand_coord($urandom_range(3));
		it.ly = rand_coord($urandom_range(3));
		it.meas = $urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(3000000));
		// landmark near the robot position so distances stay small, some coincident
		if (mode < 5) begin
			it.lx = it.rx + 32'($signed($urandom_range(400000)) - 200000);
			it.ly = it.ry + 32'($signed($urandom_range(400000)) - 200000);
		end else if (mode == 5) begin
			it.lx = it.rx;
			it.ly = it.ry;
		end
		return it;
	endfunction

	initial begin
		pose_item_t it;
		pose_item_t dir[$];
		logic [31:0] offs[6];
		quiet = 0;
		hold_sink = 0;
		done = 0;
		idle_cycles = 0;
		sb.offx = 0;
		sb.offy = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: zero distance, extremes, angle wrap, huge distance
		dir.push_back('{0, 0, 0, 0, 0, 0, 0});
		dir.push_back('{0, 0, 0, 0, 0, 0, 31'h7FFF_FFFF});
		dir.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'h7F_FFFF, 24'h7F_FFFF,
			32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF});
		dir.push_back('{32'h8000_0000, 0, 24'h80_0000, 24'h80_0000,
			32'h7FFF_FFFF, 0, 0});
		dir.push_back('{0, 32'h8000_0000, 0, 0, 0, 32'h7FFF_FFFF, 31'h7FFF_FFFF});
		dir.push_back('{100, -100, 24'd205887, 24'd0, 100, -100, 5});
		dir.push_back('{0, 0, 24'd102944, 24'd102944, 65536, 0, 65536});
		dir.push_back('{0, 0, -24'd205887, -24'd1, 0, 65536, 131072});
		dir.push_back('{0, 0, 24'd102943, 24'd0, 1, 0, 0});
		dir.push_back('{-5, 7, 24'h7F_FFFF, 24'h80_0000, -5, 7, 3});
		dir.push_back('{0, 0, 0, 0, 32'h4000_0000, 32'h4000_0000, 0});
		foreach (dir[i]) send_pose(dir[i]);
		stop_sending();
		drain();

		// mount offsets at the extremes, with the same corner poses
		offs = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000,
			32'h0000_0001, 32'h0000_0000};
		write_reg(REG_OFFSET_X, offs[0]);
		write_reg(REG_OFFSET_Y, offs[1]);
		write_reg(2'd2, 32'h1234_5678);
		write_reg(2'd3, 32'hFFFF_FFFF);
		foreach (dir[i]) send_pose(dir[i]);
		stop_sending();
		drain();

		// random phases with different offsets
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_OFFSET_X, ph < 3 ? offs[(ph + 1) % 6] : $urandom);
			write_reg(REG_OFFSET_Y, ph < 3 ? offs[(ph + 3) % 6] :
				32'($signed($urandom_range(400000)) - 200000));
			quiet = (ph == 2);
			fork
				begin
					if (ph == 4) begin
						@(negedge clk);
						hold_sink = 1;
						repeat (300) @(negedge clk);
						hold_sink = 0;
					end
				end
				begin
					for (int k = 0; k < 290; k++) begin
						it = rand_pose();
						send_pose(it);
						// pause until every result is back
						if (k == 150 && ph == 1) begin
							stop_sending();
							while (sb.pending.size() != 0) @(posedge clk);
						end
					end
				end
			join
			quiet = 0;
			stop_sending();
			drain();
		end

		done = 1;
		$display("checked %0d residuals over 8 offset settings (%0d floored, %0d clipped)",
			sb.checked, sb.floors, sb.clips);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
